>>> hdl/fpisqrt_pkg.sv
// ----------------------------------------------------------------------------
// fpisqrt_pkg
// Shared widths and default constants for the bitwise integer square root.
// ----------------------------------------------------------------------------
package fpisqrt_pkg;

    // field widths
    localparam int OPERAND_W = 64;
    localparam int ROOT_W    = 31;
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 32;

    // root digits and remainder
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_RW    = 32;
    localparam int SQRT_REM_W = 34;

    // saturation value of the result
    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    // default rescale
    localparam longint unsigned DEF_SCALE_NUM = 64'd256;
    localparam longint unsigned DEF_SCALE_DEN = 64'd65536;

endpackage

>>> hdl/fixed_point_isqrt_bitwise_top.sv
// ----------------------------------------------------------------------------
// fixed_point_isqrt_bitwise_top
// Integer square root of a signed 64-bit operand, two operand bits per cycle,
// then rescaled by SCALE_NUM / SCALE_DEN with truncation and saturation.
// ----------------------------------------------------------------------------
// channel   direction  tdata fields (low bit up)          handshake
// s_axis    in         operand[63:0]                       tvalid/tready
// m_axis    out        root[30:0], zero pad bit 31         tvalid/tready
//
// After the accept, an item passes 32 root steps of the remainder loop (one
// 34-bit subtract and compare each), a multiply state and a finish state.
// When SCALE_DEN is not a power of two, a serial restoring divider state
// between multiply and finish forms P_W quotient bits (P_W = 31 + bits of
// SCALE_NUM). One item is in work at a time; a new item is taken while the
// last result waits in the output register, and the finish state stalls
// while that register is full. Reset clears control only.
// ----------------------------------------------------------------------------
module fixed_point_isqrt_bitwise_top
    import fpisqrt_pkg::*;
#(
    parameter longint unsigned SCALE_NUM = DEF_SCALE_NUM,
    parameter longint unsigned SCALE_DEN = DEF_SCALE_DEN
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // operand[63:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata    // root[30:0], pad[31]
);

    // derived widths
    localparam int NUM_W  = $clog2(SCALE_NUM + 1);
    localparam int DEN_W  = $clog2(SCALE_DEN + 1);
    localparam int P_W    = ROOT_W + NUM_W;
    localparam int CNT_W  = $clog2(P_W);
    localparam bit DEN_POW2 = ((SCALE_DEN & (SCALE_DEN - 1)) == 0);
    localparam int DEN_SH = $clog2(SCALE_DEN);

    localparam logic [P_W-1:0]   NUM_V = P_W'(SCALE_NUM);
    localparam logic [DEN_W:0]   DEN_V = (DEN_W + 1)'(SCALE_DEN);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(P_W - 1);

    // state codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [OPERAND_W-1:0]  opnd_reg, opnd_next;
    logic [SQRT_REM_W-1:0] rem_reg, rem_next;
    logic [SQRT_RW-1:0]    root_reg, root_next;
    logic [P_W-1:0]        prod_reg, prod_next;
    logic [DEN_W-1:0]      drem_reg, drem_next;
    logic                  mval_reg, mval_next;
    logic [ROOT_W-1:0]     out_reg, out_next;

    logic                  s_accept;
    logic [SQRT_REM_W-1:0] rem_sh, trial, rem_diff;
    logic                  sq_ge;
    logic [ROOT_W-1:0]     root_cap;
    logic [DEN_W:0]        d_sh, d_diff;
    logic                  d_ge;
    logic [P_W-1:0]        quot;
    logic [ROOT_W-1:0]     result;
    logic                  out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

    // one root digit: shift in two operand bits, try root*4+1
    assign rem_sh   = {rem_reg[SQRT_REM_W-3:0], opnd_reg[OPERAND_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;
    assign sq_ge    = (rem_sh >= trial);

    // root holds 32 bits; it is saturated to 31 bits
    assign root_cap = root_reg[SQRT_RW-1] ? ROOT_MAX : root_reg[ROOT_W-1:0];

    // one quotient bit of the restoring divider
    assign d_sh   = {drem_reg, prod_reg[P_W-1]};
    assign d_diff = d_sh - DEN_V;
    assign d_ge   = (d_sh >= DEN_V);

    // quotient and saturation
    assign quot   = DEN_POW2 ? (prod_reg >> DEN_SH) : prod_reg;
    assign result = (|quot[P_W-1:ROOT_W]) ? ROOT_MAX : quot[ROOT_W-1:0];

    assign out_load = (state_reg == ST_FIN) && (!mval_reg || m_axis_tready);

    // sequencer and datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        opnd_next  = opnd_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        prod_next  = prod_reg;
        drem_next  = drem_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    // a negative operand is rooted as zero
                    opnd_next  = s_axis_tdata[OPERAND_W-1] ? '0 : s_axis_tdata;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = SQRT_LAST;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rem_next  = sq_ge ? rem_diff : rem_sh;
                root_next = {root_reg[SQRT_RW-2:0], sq_ge};
                opnd_next = {opnd_reg[OPERAND_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = P_W'(root_cap) * NUM_V;
                drem_next  = '0;
                cnt_next   = DIV_LAST;
                state_next = DEN_POW2 ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                drem_next = d_ge ? d_diff[DEN_W-1:0] : d_sh[DEN_W-1:0];
                prod_next = {prod_reg[P_W-2:0], d_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_next  = out_reg;
        mval_next = mval_reg;
        if (out_load)
        begin
            out_next  = result;
            mval_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            mval_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mval_reg  <= mval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        prod_reg <= prod_next;
        drem_reg <= drem_next;
        out_reg  <= out_next;
    end

endmodule

>>> hdl/fpisqrt_checker.sv
// ----------------------------------------------------------------------------
// fpisqrt_checker
// Port-level checks for the bitwise square root, bound to the top level.
// ----------------------------------------------------------------------------
module fpisqrt_checker
    import fpisqrt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    // a waiting result stays offered
    a_mvalid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // a waiting result does not change
    a_mdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // root is at most 31 bits, pad bit stays clear
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_OUT_W-1] == 1'b0))
        else $error("root exceeds its saturation value");

    // no result on the cycle after taking an item with nothing pending
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared before the root was finished");

endmodule

bind fixed_point_isqrt_bitwise_top fpisqrt_checker u_fpisqrt_checker (.*);
